FILE: hw/rtl/hcfc_pkg.sv
// Shared types and constants of the host command frame codec.
`timescale 1ns / 1ps

package hcfc_pkg;

	// Input opcodes
	localparam logic [1:0] OP_REQ_BYTE  = 2'd0;
	localparam logic [1:0] OP_REQ_STOP  = 2'd1;
	localparam logic [1:0] OP_RSP_HDR   = 2'd2;
	localparam logic [1:0] OP_RSP_DATA  = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_PARAM   = 2'd0;
	localparam logic [1:0] KIND_HEADER  = 2'd1;
	localparam logic [1:0] KIND_WIRE    = 2'd2;

	// Header status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD        = 2'd1;
	localparam logic [1:0] ST_INCOMPLETE = 2'd2;

	// Framing limits
	localparam logic [7:0] MAX_PARAMS    = 8'd252;
	localparam logic [7:0] VBASE_RESET   = 8'd220;
	localparam logic [8:0] POS_MAX       = 9'h1ff;
	localparam logic [8:0] HDR_BYTES     = 9'd3;

	// Work for the back end: up to three results of one kind
	typedef struct packed {
		logic [1:0]       n_res;
		logic [1:0]       kind;
		logic [2:0][7:0]  byte_list;
		logic [7:0]       command;
		logic [7:0]       version;
		logic [7:0]       params_count;
		logic [1:0]       status;
	} desc_t;

	// Queue side of the front/back boundary
	typedef struct packed {
		logic  push;
		desc_t data;
	} push_t;

endpackage

FILE: hw/rtl/hcfc_front.sv
// Front end: accepts items, tracks framing state and builds result descriptors.
`timescale 1ns / 1ps

module hcfc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [7:0]           cfg_wr_data,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic [1:0]           opcode,
	input  logic [7:0]           data_byte,
	input  logic [7:0]           result_code,
	input  logic [7:0]           rsp_size,
	input  logic                 q_full,
	output hcfc_pkg::push_t      q_push
);

	logic [7:0] vbase_q;
	logic [8:0] pos_q;
	logic [7:0] req_sum_q;
	logic [7:0] cmd_q;
	logic [7:0] ver_q;
	logic [7:0] cnt_q;
	logic [1:0] verdict_q;
	logic       old_q;
	logic [7:0] rsp_sum_q;
	logic [7:0] rsp_left_q;

	logic [8:0] pos_d;
	logic [7:0] req_sum_d;
	logic [7:0] cmd_d;
	logic [7:0] ver_d;
	logic [7:0] cnt_d;
	logic [1:0] verdict_d;
	logic       old_d;
	logic [7:0] rsp_sum_d;
	logic [7:0] rsp_left_d;
	logic       accept;
	hcfc_pkg::desc_t desc;

	assign item_ready = !q_full;
	assign accept     = item_valid && item_ready;

	// Next framing state and the results this item causes
	always_comb begin
		logic [8:0] pay_end;
		logic [7:0] size;
		logic [7:0] sum_n;
		logic [7:0] left_n;
		pay_end    = {1'b0, cnt_q} + hcfc_pkg::HDR_BYTES;
		size       = (rsp_size > hcfc_pkg::MAX_PARAMS) ? hcfc_pkg::MAX_PARAMS
			: rsp_size;
		sum_n      = 8'd0;
		left_n     = 8'd0;
		pos_d      = pos_q;
		req_sum_d  = req_sum_q;
		cmd_d      = cmd_q;
		ver_d      = ver_q;
		cnt_d      = cnt_q;
		verdict_d  = verdict_q;
		old_d      = old_q;
		rsp_sum_d  = rsp_sum_q;
		rsp_left_d = rsp_left_q;
		desc       = '0;
		case (opcode)
			hcfc_pkg::OP_REQ_BYTE: begin
				if (pos_q == 9'd0) begin
					cmd_d     = 8'd0;
					cnt_d     = 8'd0;
					verdict_d = hcfc_pkg::ST_INCOMPLETE;
					if (data_byte >= vbase_q) begin
						old_d     = 1'b0;
						ver_d     = data_byte - vbase_q;
						req_sum_d = data_byte;
					end else begin
						old_d     = 1'b1;
						cmd_d     = data_byte;
						ver_d     = 8'd0;
						cnt_d     = hcfc_pkg::MAX_PARAMS;
						req_sum_d = 8'd0;
					end
				end else if (old_q) begin
					// old style: parameters past the limit are dropped
					if (pos_q <= {1'b0, hcfc_pkg::MAX_PARAMS}) begin
						desc.n_res        = 2'd1;
						desc.kind         = hcfc_pkg::KIND_PARAM;
						desc.byte_list[0] = data_byte;
					end
				end else if (pos_q == 9'd1) begin
					cmd_d     = data_byte;
					req_sum_d = req_sum_q + data_byte;
				end else if (pos_q == 9'd2) begin
					cnt_d     = data_byte;
					req_sum_d = req_sum_q + data_byte;
				end else if (pos_q < pay_end) begin
					desc.n_res        = 2'd1;
					desc.kind         = hcfc_pkg::KIND_PARAM;
					desc.byte_list[0] = data_byte;
					req_sum_d         = req_sum_q + data_byte;
				end else if (pos_q == pay_end) begin
					verdict_d = (req_sum_q == data_byte) ? hcfc_pkg::ST_OK
						: hcfc_pkg::ST_BAD;
				end
				pos_d = (pos_q < hcfc_pkg::POS_MAX) ? pos_q + 9'd1 : hcfc_pkg::POS_MAX;
			end
			hcfc_pkg::OP_REQ_STOP: begin
				desc.n_res = 2'd1;
				desc.kind  = hcfc_pkg::KIND_HEADER;
				if (pos_q == 9'd0) begin
					desc.status = hcfc_pkg::ST_INCOMPLETE;
				end else begin
					desc.command      = cmd_q;
					desc.version      = ver_q;
					desc.params_count = cnt_q;
					desc.status       = old_q ? hcfc_pkg::ST_OK : verdict_q;
				end
				pos_d     = 9'd0;
				req_sum_d = 8'd0;
				verdict_d = hcfc_pkg::ST_INCOMPLETE;
			end
			hcfc_pkg::OP_RSP_HDR: begin
				desc.kind         = hcfc_pkg::KIND_WIRE;
				desc.byte_list[0] = result_code;
				sum_n             = old_q ? 8'd0 : result_code + size;
				if (old_q) begin
					desc.byte_list[1] = sum_n;
					desc.n_res        = (size == 8'd0) ? 2'd2 : 2'd1;
				end else begin
					desc.byte_list[1] = size;
					desc.byte_list[2] = sum_n;
					desc.n_res        = (size == 8'd0) ? 2'd3 : 2'd2;
				end
				rsp_sum_d  = sum_n;
				rsp_left_d = size;
			end
			hcfc_pkg::OP_RSP_DATA: begin
				// data with nothing outstanding is stray and dropped
				if (rsp_left_q != 8'd0) begin
					sum_n             = rsp_sum_q + data_byte;
					left_n            = rsp_left_q - 8'd1;
					desc.kind         = hcfc_pkg::KIND_WIRE;
					desc.byte_list[0] = data_byte;
					desc.byte_list[1] = sum_n;
					desc.n_res        = (left_n == 8'd0) ? 2'd2 : 2'd1;
					rsp_sum_d         = sum_n;
					rsp_left_d        = left_n;
				end
			end
			default: begin
				desc = '0;
			end
		endcase
	end

	assign q_push.push = accept && (desc.n_res != 2'd0);
	assign q_push.data = desc;

	// Version base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbase_q <= hcfc_pkg::VBASE_RESET;
		end else if (cfg_wr_en) begin
			vbase_q <= cfg_wr_data;
		end
	end

	// Framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= 9'd0;
			req_sum_q  <= 8'd0;
			cmd_q      <= 8'd0;
			ver_q      <= 8'd0;
			cnt_q      <= 8'd0;
			verdict_q  <= hcfc_pkg::ST_INCOMPLETE;
			old_q      <= 1'b0;
			rsp_sum_q  <= 8'd0;
			rsp_left_q <= 8'd0;
		end else if (accept) begin
			pos_q      <= pos_d;
			req_sum_q  <= req_sum_d;
			cmd_q      <= cmd_d;
			ver_q      <= ver_d;
			cnt_q      <= cnt_d;
			verdict_q  <= verdict_d;
			old_q      <= old_d;
			rsp_sum_q  <= rsp_sum_d;
			rsp_left_q <= rsp_left_d;
		end
	end

endmodule

FILE: hw/rtl/hcfc_queue.sv
// Descriptor queue between the front and back ends.
`timescale 1ns / 1ps

module hcfc_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hcfc_pkg::push_t      q_push,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output hcfc_pkg::desc_t      head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	hcfc_pkg::desc_t slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CNT_FULL);
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (q_push.push) begin
			slot_q[wr_ptr_q] <= q_push.data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (q_push.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (q_push.push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !q_push.push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !q_push.push)
		else $error("descriptor pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("descriptor popped from empty queue");

	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push.push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("fill count did not follow a lone push");

endmodule

FILE: hw/rtl/hcfc_back.sv
// Back end: unrolls descriptors into result items through an output register.
`timescale 1ns / 1ps

module hcfc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  hcfc_pkg::desc_t      head,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [1:0]           kind,
	output logic [7:0]           byte_value,
	output logic [7:0]           command,
	output logic [7:0]           version,
	output logic [7:0]           params_count,
	output logic [1:0]           status,
	output logic                 last
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic [7:0] cmd_q;
	logic [7:0] ver_q;
	logic [7:0] cnt_q;
	logic [1:0] status_q;
	logic       last_q;
	logic       load;
	logic       final_res;

	assign load      = !empty && (!out_valid_q || result_ready);
	assign final_res = (idx_q == head.n_res - 2'd1);
	assign pop       = load && final_res;

	// Result index within the head descriptor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (load) begin
			idx_q <= final_res ? 2'd0 : idx_q + 2'd1;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= head.kind;
			byte_q   <= head.byte_list[idx_q];
			cmd_q    <= head.command;
			ver_q    <= head.version;
			cnt_q    <= head.params_count;
			status_q <= head.status;
			last_q   <= final_res;
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = kind_q;
	assign byte_value   = byte_q;
	assign command      = cmd_q;
	assign version      = ver_q;
	assign params_count = cnt_q;
	assign status       = status_q;
	assign last         = last_q;

	a_head_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (head.n_res != 2'd0))
		else $error("queued descriptor carries no results");

	a_header_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == hcfc_pkg::KIND_HEADER) |-> last_q)
		else $error("header result not marked last");

endmodule

FILE: hw/rtl/host_command_frame_codec.sv
// Top level of the host command frame codec.
`timescale 1ns / 1ps

// Deframes host request bytes and frames response bytes with a byte-sum
// checksum. The front end takes one item per clock while the descriptor
// queue (QUEUE_DEPTH entries) has room, updates the framing state in that
// cycle and queues the zero to three results the item causes. The back end
// sends one result per clock while result_ready is high, through a registered
// output. An item causes one result for a parameter byte or a request stop,
// one to three for a response item, none for a byte that only updates state
// or is dropped. The output rate sets the sustained throughput; an item's
// first result passes the queue storage, then the output register.
// version_base is written through cfg_wr_en/cfg_wr_data and resets to 220.
module host_command_frame_codec #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] data_byte,
	input  logic [7:0] result_code,
	input  logic [7:0] rsp_size,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [1:0] kind,
	output logic [7:0] byte_value,
	output logic [7:0] command,
	output logic [7:0] version,
	output logic [7:0] params_count,
	output logic [1:0] status,
	output logic       last
);

	hcfc_pkg::push_t q_push;
	hcfc_pkg::desc_t head;
	logic            q_full;
	logic            q_empty;
	logic            q_pop;

	// Classification and framing state
	hcfc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.opcode        (opcode),
		.data_byte     (data_byte),
		.result_code   (result_code),
		.rsp_size      (rsp_size),
		.q_full        (q_full),
		.q_push        (q_push)
	);

	// Decoupling queue
	hcfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.head   (head)
	);

	// Result sequencing
	hcfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (q_empty),
		.head         (head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kind         (kind),
		.byte_value   (byte_value),
		.command      (command),
		.version      (version),
		.params_count (params_count),
		.status       (status),
		.last         (last)
	);

endmodule

FILE: dv/host_command_frame_codec_tb.sv
// Self-checking testbench for the host command frame codec.
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 45;
	localparam int NUM_PHASES    = 5;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data_byte;
		logic [7:0] result_code;
		logic [7:0] rsp_size;
	} codec_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_value;
		logic [7:0] command;
		logic [7:0] version;
		logic [7:0] params_count;
		logic [1:0] status;
		logic       last;
	} codec_result_t;

	// Tracks the framing state and holds the results still due from the block
	class frame_scoreboard;
		logic [7:0]    vbase;
		logic [8:0]    position;
		logic [7:0]    req_sum;
		logic [7:0]    held_cmd;
		logic [7:0]    held_ver;
		logic [7:0]    held_cnt;
		logic [1:0]    verdict;
		logic          old_style;
		logic [7:0]    rsp_sum;
		logic [7:0]    rsp_left;
		codec_result_t due_results[$];
		int            errors;
		int            checked;

		function new();
			vbase     = hcfc_pkg::VBASE_RESET;
			position  = '0;
			req_sum   = '0;
			held_cmd  = '0;
			held_ver  = '0;
			held_cnt  = '0;
			verdict   = hcfc_pkg::ST_INCOMPLETE;
			old_style = 1'b0;
			rsp_sum   = '0;
			rsp_left  = '0;
			errors    = 0;
			checked   = 0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void set_base(logic [7:0] v);
			vbase = v;
		endfunction

		function void queue_result(logic [1:0] k, logic [7:0] bv, logic [7:0] c,
				logic [7:0] v, logic [7:0] n, logic [1:0] st);
			codec_result_t r;
			r.kind         = k;
			r.byte_value   = bv;
			r.command      = c;
			r.version      = v;
			r.params_count = n;
			r.status       = st;
			r.last         = 1'b0;
			due_results.push_back(r);
		endfunction

		// Data-only result of the given kind
		function void queue_byte(logic [1:0] k, logic [7:0] bv);
			queue_result(k, bv, 8'd0, 8'd0, 8'd0, hcfc_pkg::ST_OK);
		endfunction

		// Advances the framing state by one accepted item; returns 0 if the item was ignored
		function bit note_item(codec_item_t it);
			int         before_n;
			int         p;
			logic [7:0] sz;
			bit         used;
			before_n = due_results.size();
			p        = position;
			used     = 1'b1;
			case (it.op)
			hcfc_pkg::OP_REQ_BYTE: begin
				if (p == 0) begin
					held_cmd = '0;
					held_cnt = '0;
					verdict  = hcfc_pkg::ST_INCOMPLETE;
					if (it.data_byte >= vbase) begin
						old_style = 1'b0;
						held_ver  = it.data_byte - vbase;
						req_sum   = it.data_byte;
					end else begin
						old_style = 1'b1;
						held_cmd  = it.data_byte;
						held_ver  = '0;
						held_cnt  = hcfc_pkg::MAX_PARAMS;
						req_sum   = '0;
					end
				end else if (old_style) begin
					// old-style parameters past the maximum are dropped
					if (p <= int'(hcfc_pkg::MAX_PARAMS))
						queue_byte(hcfc_pkg::KIND_PARAM, it.data_byte);
					else
						used = 1'b0;
				end else if (p == 1) begin
					held_cmd = it.data_byte;
					req_sum  = req_sum + it.data_byte;
				end else if (p == 2) begin
					held_cnt = it.data_byte;
					req_sum  = req_sum + it.data_byte;
				end else if (p < int'(held_cnt) + int'(hcfc_pkg::HDR_BYTES)) begin
					queue_byte(hcfc_pkg::KIND_PARAM, it.data_byte);
					req_sum = req_sum + it.data_byte;
				end else if (p == int'(held_cnt) + int'(hcfc_pkg::HDR_BYTES)) begin
					verdict = (req_sum == it.data_byte) ? hcfc_pkg::ST_OK
						: hcfc_pkg::ST_BAD;
				end else begin
					used = 1'b0;
				end
				position = (p < int'(hcfc_pkg::POS_MAX)) ? 9'(p + 1) : hcfc_pkg::POS_MAX;
			end
			hcfc_pkg::OP_REQ_STOP: begin
				if (p == 0)
					queue_result(hcfc_pkg::KIND_HEADER, 8'd0, 8'd0, 8'd0, 8'd0,
						hcfc_pkg::ST_INCOMPLETE);
				else
					queue_result(hcfc_pkg::KIND_HEADER, 8'd0, held_cmd, held_ver,
						held_cnt, old_style ? hcfc_pkg::ST_OK : verdict);
				position = '0;
				req_sum  = '0;
				verdict  = hcfc_pkg::ST_INCOMPLETE;
			end
			hcfc_pkg::OP_RSP_HDR: begin
				sz = (it.rsp_size > hcfc_pkg::MAX_PARAMS) ? hcfc_pkg::MAX_PARAMS
					: it.rsp_size;
				queue_byte(hcfc_pkg::KIND_WIRE, it.result_code);
				if (!old_style) begin
					queue_byte(hcfc_pkg::KIND_WIRE, sz);
					rsp_sum = it.result_code + sz;
				end else begin
					rsp_sum = '0;
				end
				rsp_left = sz;
				if (sz == 0)
					queue_byte(hcfc_pkg::KIND_WIRE, rsp_sum);
			end
			default: begin
				if (rsp_left != 0) begin
					queue_byte(hcfc_pkg::KIND_WIRE, it.data_byte);
					rsp_sum  = rsp_sum + it.data_byte;
					rsp_left = rsp_left - 8'd1;
					if (rsp_left == 0)
						queue_byte(hcfc_pkg::KIND_WIRE, rsp_sum);
				end else begin
					used = 1'b0;
				end
			end
			endcase
			if (due_results.size() > before_n)
				due_results[due_results.size() - 1].last = 1'b1;
			return used;
		endfunction

		function string show(codec_result_t r);
			return $sformatf(
				"kind=%0d byte=%02h cmd=%02h ver=%02h cnt=%0d st=%0d last=%0d",
				r.kind, r.byte_value, r.command, r.version, r.params_count, r.status,
				r.last);
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH: %s", msg);
		endtask

		task check_result(codec_result_t got);
			codec_result_t want;
			if (due_results.size() == 0) begin
				report($sformatf("result with nothing due: %s", show(got)));
			end else begin
				want = due_results.pop_front();
				checked++;
				if (got.kind !== want.kind || got.byte_value !== want.byte_value ||
						got.command !== want.command || got.version !== want.version ||
						got.params_count !== want.params_count ||
						got.status !== want.status || got.last !== want.last)
					report($sformatf("result %0d: got %s, want %s", checked, show(got),
						show(want)));
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       item_valid;
	logic       item_ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;
	logic [7:0] result_code;
	logic [7:0] rsp_size;
	logic       result_valid;
	logic       result_ready;
	logic [1:0] kind;
	logic [7:0] byte_value;
	logic [7:0] command;
	logic [7:0] version;
	logic [7:0] params_count;
	logic [1:0] status;
	logic       last;

	frame_scoreboard sb;
	bit              idling_on     = 1'b1;
	int              counted_items = 0;
	int              cycle_count   = 0;
	int              stall_left    = 0;

	host_command_frame_codec dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.opcode       (opcode),
		.data_byte    (data_byte),
		.result_code  (result_code),
		.rsp_size     (rsp_size),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kind         (kind),
		.byte_value   (byte_value),
		.command      (command),
		.version      (version),
		.params_count (params_count),
		.status       (status),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: check accepted results, stall in short bursts
	initial begin
		codec_result_t got;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (result_valid && result_ready) begin
					got = '{kind, byte_value, command, version, params_count, status, last};
					sb.check_result(got);
				end
				if (stall_left > 0) begin
					stall_left--;
					result_ready <= 1'b0;
				end else if (idling_on && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 3) - 1;
					result_ready <= 1'b0;
				end else begin
					result_ready <= 1'b1;
				end
			end
		end
	end

	// Offer one item, hold it until accepted, then log it
	task automatic send_item(logic [1:0] op, logic [7:0] db, logic [7:0] rc, logic [7:0] sz);
		codec_item_t it;
		it = '{op, db, rc, sz};
		if (idling_on && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		item_valid  <= 1'b1;
		opcode      <= op;
		data_byte   <= db;
		result_code <= rc;
		rsp_size    <= sz;
		do @(posedge clk); while (!item_ready);
		if (sb.note_item(it))
			counted_items++;
	endtask

	task automatic send_req_byte(logic [7:0] b);
		send_item(hcfc_pkg::OP_REQ_BYTE, b, 8'($urandom), 8'($urandom_range(0, 252)));
	endtask

	task automatic send_stop();
		send_item(hcfc_pkg::OP_REQ_STOP, 8'($urandom), 8'($urandom),
			8'($urandom_range(0, 252)));
	endtask

	// Hold off the sender until every due result is out and the block is quiet
	task automatic settle();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(logic [7:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		sb.set_base(v);
		cfg_wr_en <= 1'b0;
	endtask

	// Versioned request, mostly well formed
	task automatic new_style_request();
		logic [7:0] frame_q[$];
		logic [7:0] sum;
		int         count;
		int         shape;
		int         cut;
		frame_q.push_back(8'(int'(sb.vbase) + $urandom_range(0, 255 - int'(sb.vbase))));
		frame_q.push_back(8'($urandom));
		count = ($urandom_range(0, 29) == 0) ? $urandom_range(5, 255) : $urandom_range(0, 4);
		frame_q.push_back(8'(count));
		repeat (count) frame_q.push_back(8'($urandom));
		sum = '0;
		foreach (frame_q[i]) sum = sum + frame_q[i];
		shape = $urandom_range(0, 7);
		if (shape == 0) begin
			// stopped early, before the checksum
			cut = $urandom_range(0, frame_q.size());
			for (int i = 0; i < cut; i++) send_req_byte(frame_q[i]);
		end else begin
			if ($urandom_range(0, 4) == 0)
				sum = sum ^ 8'($urandom_range(1, 255));
			frame_q.push_back(sum);
			if (shape == 1)
				repeat ($urandom_range(1, 2)) frame_q.push_back(8'($urandom));
			foreach (frame_q[i]) send_req_byte(frame_q[i]);
		end
		send_stop();
	endtask

	task automatic old_style_request(int n_params);
		send_req_byte(8'($urandom_range(0, int'(sb.vbase) - 1)));
		repeat (n_params) send_req_byte(8'($urandom));
		send_stop();
	endtask

	task automatic response_frame();
		int sz;
		int n_data;
		int pick;
		pick = $urandom_range(0, 29);
		if (pick == 0)
			sz = 252;
		else if (pick < 3)
			sz = $urandom_range(6, 252);
		else
			sz = $urandom_range(0, 5);
		send_item(hcfc_pkg::OP_RSP_HDR, 8'($urandom), 8'($urandom), 8'(sz));
		n_data = ($urandom_range(0, 5) == 0) ? $urandom_range(0, sz) : sz;
		if ($urandom_range(0, 7) == 0)
			n_data = n_data + $urandom_range(1, 2);
		repeat (n_data)
			send_item(hcfc_pkg::OP_RSP_DATA, 8'($urandom), 8'($urandom),
				8'($urandom_range(0, 252)));
	endtask

	task automatic random_transaction();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45 || (pick < 65 && sb.vbase == 0))
			new_style_request();
		else if (pick < 65)
			old_style_request($urandom_range(0, 6));
		else if (pick < 90)
			response_frame();
		else
			send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
				8'($urandom_range(0, 252)));
	endtask

	// Short hand-picked sequence at the reset base
	task automatic directed_items();
		// stop with nothing received
		send_item(hcfc_pkg::OP_REQ_STOP, 8'h00, 8'h00, 8'h00);
		// versioned frame at top version, good checksum, a trailing byte
		send_item(hcfc_pkg::OP_REQ_BYTE, 8'hFF, 8'h00, 8'h00);
		send_item(hcfc_pkg::OP_REQ_BYTE, 8'hAB, 8'h00, 8'h00);
		send_item(hcfc_pkg::OP_REQ_BYTE, 8'h02, 8'h00, 8'h00);
		send_item(hcfc_pkg::OP_REQ_BYTE, 8'h00, 8'h00, 8'h00);
		send_item(hcfc_pkg::OP_REQ_BYTE, 8'hFF, 8'h00, 8'h00);
		send_item(hcfc_pkg::OP_REQ_BYTE, 8'hAB, 8'h00, 8'h00);
		send_item(hcfc_pkg::OP_REQ_BYTE, 8'h77, 8'h00, 8'h00);
		send_item(hcfc_pkg::OP_REQ_STOP, 8'h00, 8'h00, 8'h00);
		// versioned frame cut after the command
		send_item(hcfc_pkg::OP_REQ_BYTE, 8'd220, 8'h00, 8'h00);
		send_item(hcfc_pkg::OP_REQ_BYTE, 8'h12, 8'h00, 8'h00);
		send_item(hcfc_pkg::OP_REQ_STOP, 8'h00, 8'h00, 8'h00);
		// old-style command, then an old-style response and a stray data byte
		send_item(hcfc_pkg::OP_REQ_BYTE, 8'h00, 8'h00, 8'h00);
		send_item(hcfc_pkg::OP_REQ_BYTE, 8'h55, 8'h00, 8'h00);
		send_item(hcfc_pkg::OP_REQ_STOP, 8'h00, 8'h00, 8'h00);
		send_item(hcfc_pkg::OP_RSP_HDR, 8'h00, 8'hFF, 8'd1);
		send_item(hcfc_pkg::OP_RSP_DATA, 8'h01, 8'h00, 8'h00);
		send_item(hcfc_pkg::OP_RSP_DATA, 8'h80, 8'h00, 8'h00);
		// versioned frame with a wrong checksum
		send_item(hcfc_pkg::OP_REQ_BYTE, 8'd221, 8'h00, 8'h00);
		send_item(hcfc_pkg::OP_REQ_BYTE, 8'h05, 8'h00, 8'h00);
		send_item(hcfc_pkg::OP_REQ_BYTE, 8'h00, 8'h00, 8'h00);
		send_item(hcfc_pkg::OP_REQ_BYTE, 8'h00, 8'h00, 8'h00);
		send_item(hcfc_pkg::OP_REQ_STOP, 8'h00, 8'h00, 8'h00);
		// largest response cut off by a zero-size one
		send_item(hcfc_pkg::OP_RSP_HDR, 8'h00, 8'h5A, 8'd252);
		send_item(hcfc_pkg::OP_RSP_HDR, 8'h00, 8'hA5, 8'd0);
	endtask

	// Stimulus
	initial begin
		logic [7:0] bases [NUM_PHASES];
		int         phase_start;
		sb = new();
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		item_valid  <= 1'b0;
		opcode      <= hcfc_pkg::OP_REQ_BYTE;
		data_byte   <= '0;
		result_code <= '0;
		rsp_size    <= '0;
		bases = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254)), hcfc_pkg::VBASE_RESET};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_items();

		// one phase per version base, the last one without idling
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			if (ph == NUM_PHASES - 1)
				idling_on = 1'b0;
			write_base(bases[ph]);
			phase_start = counted_items;
			while (counted_items - phase_start < PHASE_ITEMS)
				random_transaction();
		end

		settle();
		$display("covered %0d effective items over %0d version base phases",
			counted_items, NUM_PHASES + 1);
		$display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/hcfc_pkg.sv
hw/rtl/hcfc_front.sv
hw/rtl/hcfc_queue.sv
hw/rtl/hcfc_back.sv
hw/rtl/host_command_frame_codec.sv
dv/host_command_frame_codec_tb.sv
